FILE: hdl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Field layouts of both channels, command and status groups, result codes.
// ----------------------------------------------------------------------------
package spq_pkg;

	// storage geometry
	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 32;
	localparam int PRIO_BITS  = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// external field widths
	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 32;
	localparam int COUNT_W = 5;

	// operation codes
	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                     mode;
		logic [VALUE_W-1:0]       item_value;
		logic signed [PRIO_W-1:0] item_priority;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [VALUE_W-1:0] out_value;
		logic               now_empty;
		logic [COUNT_W-1:0] entry_count;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

FILE: hdl/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: bounded priority queue, highest priority first
// Enqueue places an entry behind all entries of equal or higher priority;
// dequeue returns and removes the head. One result per request.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready   | in_data  (mode, value, priority)
//   out     | output    | out_valid / out_ready | out_data (status, value, empty, count)
//
// A request is first captured in the request register; then all entry cells
// compare against it in parallel and shift, loading the result register.
// The execute cycle waits while the result register holds an untaken result.
// Reset clears the count and control state only; cells past the count are never read.
// The next request is taken once the previous one has been committed.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  spq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output spq_pkg::out_item_t out_data
);

	spq_pkg::dp_cmd_t  cmd;
	spq_pkg::dp_stat_t stat;

	// sequencing
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// entry cells and result register
	spq_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

FILE: hdl/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl: sequencing of the sorted priority queue
// Takes one request, runs it through the datapath when the result register
// is free, and tracks the valid flag of the result register.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output spq_pkg::dp_cmd_t  cmd,
	input  spq_pkg::dp_stat_t stat
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// handshake and commands
	assign in_ready    = (state_q == S_IDLE);
	assign cmd.load_in = in_valid && in_ready;
	assign cmd.commit  = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.load_in) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.commit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a commit always leaves a result waiting
	a_commit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not load the result register");

	// a request held back by a blocked result stays in execution
	a_exec_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && out_valid_q && !out_ready |=> (state_q == S_EXEC))
		else $error("request left execution while result was blocked");

	// no new request is taken while one is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> !cmd.load_in)
		else $error("request taken while another was pending");

	// the store cannot be full and empty at once
	a_stat_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("store reported full and empty");

endmodule

FILE: hdl/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath: sorted entry cells and result register
// Every cell compares its priority with the request at once; an enqueue
// shifts the lower cells down by one, a dequeue shifts all cells but the last up by one.
// ----------------------------------------------------------------------------
module spq_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::in_item_t  in_data,
	input  spq_pkg::dp_cmd_t   cmd,
	output spq_pkg::dp_stat_t  stat,
	output spq_pkg::out_item_t out_data
);

	localparam int DEPTH = spq_pkg::DEPTH;
	localparam int CNT_W = spq_pkg::CNT_W;

	// request register
	logic                              mode_q;
	logic [spq_pkg::VALUE_BITS-1:0]    req_val_q;
	logic signed [spq_pkg::PRIO_BITS-1:0] req_prio_q;

	// entry cells, head at index 0
	logic [spq_pkg::VALUE_BITS-1:0]       slot_val_q  [DEPTH];
	logic signed [spq_pkg::PRIO_BITS-1:0] slot_prio_q [DEPTH];
	logic [CNT_W-1:0]                     count_q;
	logic [CNT_W-1:0]                     count_d;

	spq_pkg::out_item_t res_q;
	spq_pkg::out_item_t res_d;

	logic [DEPTH-1:0] ge;
	logic [DEPTH-1:0] order_ok;
	logic             do_enq;
	logic             do_deq;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_enq     = cmd.commit && (mode_q == spq_pkg::MODE_ENQ) && !stat.full;
	assign do_deq     = cmd.commit && (mode_q == spq_pkg::MODE_DEQ) && !stat.empty;
	assign out_data   = res_q;

	// capture the request
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q     <= in_data.mode;
			req_val_q  <= in_data.item_value[spq_pkg::VALUE_BITS-1:0];
			req_prio_q <= in_data.item_priority[spq_pkg::PRIO_BITS-1:0];
		end
	end

	// per-cell compare: occupied and at least the new priority
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge[i] = (CNT_W'(i) < count_q) && (slot_prio_q[i] >= req_prio_q);
		end
	end

	// cell updates
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_enq && !ge[i]) begin
				if (i == 0) begin
					slot_val_q[i]  <= req_val_q;
					slot_prio_q[i] <= req_prio_q;
				end else if (ge[(i > 0) ? i - 1 : 0]) begin
					slot_val_q[i]  <= req_val_q;
					slot_prio_q[i] <= req_prio_q;
				end else begin
					slot_val_q[i]  <= slot_val_q[(i > 0) ? i - 1 : 0];
					slot_prio_q[i] <= slot_prio_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_deq && (i < DEPTH - 1)) begin
				slot_val_q[i]  <= slot_val_q[(i < DEPTH - 1) ? i + 1 : i];
				slot_prio_q[i] <= slot_prio_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	// next count and result
	always_comb begin
		count_d = count_q;
		if (do_enq) count_d = count_q + CNT_W'(1);
		else if (do_deq) count_d = count_q - CNT_W'(1);

		res_d.status    = spq_pkg::ST_OK;
		res_d.out_value = '0;
		if (mode_q == spq_pkg::MODE_ENQ) begin
			if (stat.full) res_d.status = spq_pkg::ST_FULL;
		end else begin
			if (stat.empty) res_d.status = spq_pkg::ST_EMPTY;
			else res_d.out_value = spq_pkg::VALUE_W'(slot_val_q[0]);
		end
		res_d.now_empty   = (count_d == '0);
		res_d.entry_count = spq_pkg::COUNT_W'(count_d);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) res_q <= res_d;
	end

	// adjacent occupied cells stay in descending priority order
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (i < DEPTH - 1) begin
				order_ok[i] = (CNT_W'(i + 1) >= count_q) ||
					(slot_prio_q[i] >= slot_prio_q[(i < DEPTH - 1) ? i + 1 : i]);
			end else begin
				order_ok[i] = 1'b1;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond capacity");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		&order_ok)
		else $error("entry cells out of priority order");

	a_reject_stable: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !do_enq && !do_deq |=> $stable(count_q))
		else $error("rejected request changed the entry count");

endmodule
